@@ rtl/core/gcdisp_pkg.sv @@
// ----------------------------------------------------------------------------
// gcdisp_pkg
// Shared widths, codes, reset values and types of the cash dispenser.
// ----------------------------------------------------------------------------
package gcdisp_pkg;

    localparam int DEN_W   = 16;
    localparam int CNT_W   = 8;
    localparam int AMT_W   = 24;
    localparam int FUNDS_W = 27;
    localparam int ODDS_W  = 8;
    localparam int BET_W   = 16;

    localparam logic [CNT_W-1:0] STOCK_RESET  = 8'd10;
    localparam logic [CNT_W-1:0] REFILL_RESET = 8'd10;

    typedef enum logic [0:0] {
        REQ_PAYOUT = 1'b0,
        REQ_REFILL = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        PAY_OK      = 2'd0,
        PAY_REFUSED = 2'd1,
        PAY_REFILL  = 2'd2
    } status_t;

    // result of one greedy pick over a single denomination
    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] notes;
        logic [AMT_W-1:0] rem;
    } pick_res_t;

    function automatic logic [DEN_W-1:0] denom_reset(input int i);
        logic [DEN_W-1:0] v;
        case (i)
            0:       v = 16'd1;
            1:       v = 16'd5;
            2:       v = 16'd10;
            3:       v = 16'd20;
            4:       v = 16'd100;
            5:       v = 16'd200;
            default: v = 16'd500;
        endcase
        return v;
    endfunction

    // value held after reset: every stock full at its reset count
    function automatic logic [FUNDS_W-1:0] reset_funds(input int n);
        logic [FUNDS_W-1:0] s;
        s = '0;
        for (int i = 0; i < n; i++)
            s = s + FUNDS_W'(STOCK_RESET) * FUNDS_W'(denom_reset(i));
        return s;
    endfunction

endpackage

@@ rtl/core/gcdisp_regs.sv @@
// ----------------------------------------------------------------------------
// gcdisp_regs
// Configuration register file: denominations and refill level behind APB.
// ----------------------------------------------------------------------------
module gcdisp_regs import gcdisp_pkg::*; #(
    parameter int NUM_DENOMS = 5,
    parameter int AW         = 5
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [AW-1:0]                      paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output logic [NUM_DENOMS-1:0][DEN_W-1:0]   denom,
    output logic [CNT_W-1:0]                   refill_level
);

    localparam int IW = AW - 2;
    localparam logic [IW-1:0] IDX_REFILL = IW'(NUM_DENOMS);

    logic [NUM_DENOMS-1:0][DEN_W-1:0] denom_reg;
    logic [CNT_W-1:0]                 refill_reg;
    logic [IW-1:0]                    idx;
    logic                             wr_en;

    assign idx    = paddr[AW-1:2];
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DENOMS; i++)
                denom_reg[i] <= denom_reset(i);
            refill_reg <= REFILL_RESET;
        end
        else if (wr_en)
        begin
            if (idx < IDX_REFILL)
                denom_reg[idx] <= pwdata[DEN_W-1:0];
            else if (idx == IDX_REFILL)
                refill_reg <= pwdata[CNT_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (idx < IDX_REFILL)
            prdata = 32'(denom_reg[idx]);
        else if (idx == IDX_REFILL)
            prdata = 32'(refill_reg);
    end

    assign denom        = denom_reg;
    assign refill_level = refill_reg;

endmodule

@@ rtl/core/gcdisp_mul.sv @@
// ----------------------------------------------------------------------------
// gcdisp_mul
// Shift-and-add multiplier: 8-bit multiplier taken one bit per cycle.
// ----------------------------------------------------------------------------
module gcdisp_mul import gcdisp_pkg::*; #(
    parameter int B_W = 19
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [7:0]       a,
    input  logic [B_W-1:0]   b,
    output logic             done,
    output logic [B_W+7:0]   prod
);

    logic           busy_reg;
    logic           done_reg;
    logic [2:0]     cnt_reg;
    logic [7:0]     a_reg;
    logic [B_W+7:0] mcand_reg;
    logic [B_W+7:0] acc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd7)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg     <= a;
            mcand_reg <= (B_W+8)'(b);
            acc_reg   <= '0;
        end
        else if (busy_reg)
        begin
            if (a_reg[0])
                acc_reg <= acc_reg + mcand_reg;
            a_reg     <= a_reg >> 1;
            mcand_reg <= mcand_reg << 1;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

@@ rtl/core/gcdisp_pick.sv @@
// ----------------------------------------------------------------------------
// gcdisp_pick
// Greedy note count for one denomination, one count bit per cycle.
// ----------------------------------------------------------------------------
module gcdisp_pick import gcdisp_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [AMT_W-1:0] rem,
    input  logic [DEN_W-1:0] denom,
    input  logic [CNT_W-1:0] stock,
    output pick_res_t        res
);

    logic                   busy_reg;
    logic                   done_reg;
    logic [AMT_W-1:0]       r_reg;
    logic [CNT_W-1:0]       n_reg;
    logic [CNT_W-1:0]       bit_reg;
    logic [DEN_W+CNT_W-2:0] dsh_reg;
    logic                   nz_reg;
    logic [CNT_W-1:0]       trial_n;
    logic                   take;

    // largest count within both remainder and stock, built msb first
    assign trial_n = n_reg | bit_reg;
    assign take    = nz_reg && (AMT_W'(dsh_reg) <= r_reg) && (trial_n <= stock);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            else if (busy_reg && bit_reg[0])
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg   <= rem;
            n_reg   <= '0;
            bit_reg <= {1'b1, {(CNT_W-1){1'b0}}};
            dsh_reg <= {denom, {(CNT_W-1){1'b0}}};
            nz_reg  <= (denom != '0);
        end
        else if (busy_reg)
        begin
            if (take)
            begin
                r_reg <= r_reg - AMT_W'(dsh_reg);
                n_reg <= trial_n;
            end
            bit_reg <= bit_reg >> 1;
            dsh_reg <= dsh_reg >> 1;
        end
    end

    assign res.done  = done_reg;
    assign res.notes = n_reg;
    assign res.rem   = r_reg;

endmodule

@@ rtl/core/greedy_cash_dispenser.sv @@
// ----------------------------------------------------------------------------
// greedy_cash_dispenser
// Note dispenser with per-denomination stocks and greedy payout.
// ----------------------------------------------------------------------------
// One request is handled at a time. A payout runs odds times bet through
// the shift-and-add multiplier, then goes through the denominations in the
// picker, which settles one bit of the note count per cycle. A refused
// payout ends after the multiplier. A refill sums the denominations one per
// cycle and then makes one pass through the multiplier with the refill
// level. A finished result sits in the output register while the next
// request is taken. Denominations should be written strictly ascending;
// the payout runs from the highest index down regardless.
// ----------------------------------------------------------------------------
module greedy_cash_dispenser import gcdisp_pkg::*; #(
    parameter  int NUM_DENOMS = 5,
    localparam int AW         = $clog2(NUM_DENOMS + 1) + 2,
    localparam int OUT_BITS   = AMT_W + CNT_W * NUM_DENOMS + AMT_W + FUNDS_W,
    localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [23:0]         s_tdata,   // odds[7:0], bet[23:8]
    input  logic                s_tuser,   // req_type
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OUT_W-1:0]    m_tdata,   // amount, count_0.., undispensed, funds_left
    output logic [1:0]          m_tuser,   // status
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [AW-1:0]       paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int SUM_W   = DEN_W + $clog2(NUM_DENOMS + 1);
    localparam int P_W     = SUM_W + 8;
    localparam int IDX_W   = (NUM_DENOMS > 1) ? $clog2(NUM_DENOMS) : 1;
    localparam int OFS_CNT = AMT_W;
    localparam int OFS_REM = AMT_W + CNT_W * NUM_DENOMS;
    localparam int OFS_FND = OFS_REM + AMT_W;
    localparam logic [IDX_W-1:0]   IDX_LAST    = IDX_W'(NUM_DENOMS - 1);
    localparam logic [FUNDS_W-1:0] FUNDS_RESET = reset_funds(NUM_DENOMS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_PSTART,
        ST_PWAIT,
        ST_SUM,
        ST_RMUL,
        ST_FIN
    } state_t;

    state_t state_reg, state_next;

    logic [NUM_DENOMS-1:0][CNT_W-1:0] stock_reg, stock_next;
    logic [NUM_DENOMS-1:0][CNT_W-1:0] count_reg, count_next;
    logic [FUNDS_W-1:0]               total_reg, total_next;
    logic [AMT_W-1:0]                 amount_reg, amount_next;
    logic [AMT_W-1:0]                 rem_reg, rem_next;
    logic [IDX_W-1:0]                 idx_reg, idx_next;
    logic [SUM_W-1:0]                 sum_reg, sum_next;
    status_t                          status_reg, status_next;
    logic                             m_tvalid_reg, m_tvalid_next;
    logic [OUT_W-1:0]                 m_tdata_reg, m_tdata_next;
    logic [1:0]                       m_tuser_reg, m_tuser_next;

    logic [NUM_DENOMS-1:0][DEN_W-1:0] denom;
    logic [CNT_W-1:0]                 refill_level;
    logic                             mul_start;
    logic [7:0]                       mul_a;
    logic [SUM_W-1:0]                 mul_b;
    logic                             mul_done;
    logic [P_W-1:0]                   mul_prod;
    logic                             pick_start;
    pick_res_t                        pick_res;
    logic [SUM_W-1:0]                 sum_add;

    gcdisp_regs #(
        .NUM_DENOMS (NUM_DENOMS),
        .AW         (AW)
    ) u_regs (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .denom        (denom),
        .refill_level (refill_level)
    );

    gcdisp_mul #(
        .B_W (SUM_W)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    gcdisp_pick u_pick (
        .clk   (clk),
        .rst_n (rst_n),
        .start (pick_start),
        .rem   (rem_reg),
        .denom (denom[idx_reg]),
        .stock (stock_reg[idx_reg]),
        .res   (pick_res)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign sum_add  = sum_reg + SUM_W'(denom[idx_reg]);

    always_comb
    begin
        state_next    = state_reg;
        stock_next    = stock_reg;
        count_next    = count_reg;
        total_next    = total_reg;
        amount_next   = amount_reg;
        rem_next      = rem_reg;
        idx_next      = idx_reg;
        sum_next      = sum_reg;
        status_next   = status_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        mul_start     = 1'b0;
        mul_a         = s_tdata[ODDS_W-1:0];
        mul_b         = SUM_W'(s_tdata[ODDS_W +: BET_W]);
        pick_start    = 1'b0;

        if (m_tvalid_reg && m_tready)
            m_tvalid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    count_next = '0;
                    if (s_tuser == REQ_REFILL)
                    begin
                        amount_next = '0;
                        rem_next    = '0;
                        sum_next    = '0;
                        idx_next    = IDX_LAST;
                        state_next  = ST_SUM;
                    end
                    else
                    begin
                        mul_start  = 1'b1;
                        state_next = ST_MUL;
                    end
                end
            end
            ST_MUL:
            begin
                if (mul_done)
                begin
                    amount_next = mul_prod[AMT_W-1:0];
                    if (FUNDS_W'(mul_prod[AMT_W-1:0]) > total_reg)
                    begin
                        rem_next    = '0;
                        status_next = PAY_REFUSED;
                        state_next  = ST_FIN;
                    end
                    else
                    begin
                        rem_next   = mul_prod[AMT_W-1:0];
                        idx_next   = IDX_LAST;
                        state_next = ST_PSTART;
                    end
                end
            end
            ST_PSTART:
            begin
                pick_start = 1'b1;
                state_next = ST_PWAIT;
            end
            ST_PWAIT:
            begin
                if (pick_res.done)
                begin
                    count_next[idx_reg] = pick_res.notes;
                    stock_next[idx_reg] = stock_reg[idx_reg] - pick_res.notes;
                    rem_next            = pick_res.rem;
                    if (idx_reg == '0)
                    begin
                        // everything paid in this request leaves the total at once
                        total_next  = total_reg - FUNDS_W'(amount_reg - pick_res.rem);
                        status_next = PAY_OK;
                        state_next  = ST_FIN;
                    end
                    else
                    begin
                        idx_next   = idx_reg - IDX_W'(1);
                        state_next = ST_PSTART;
                    end
                end
            end
            ST_SUM:
            begin
                sum_next = sum_add;
                if (idx_reg == '0)
                begin
                    mul_start  = 1'b1;
                    mul_a      = refill_level;
                    mul_b      = sum_add;
                    state_next = ST_RMUL;
                end
                else
                    idx_next = idx_reg - IDX_W'(1);
            end
            ST_RMUL:
            begin
                if (mul_done)
                begin
                    total_next = FUNDS_W'(mul_prod);
                    for (int i = 0; i < NUM_DENOMS; i++)
                        stock_next[i] = refill_level;
                    status_next = PAY_REFILL;
                    state_next  = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    m_tdata_next[0 +: AMT_W] = amount_reg;
                    for (int i = 0; i < NUM_DENOMS; i++)
                        m_tdata_next[OFS_CNT + CNT_W * i +: CNT_W] = count_reg[i];
                    m_tdata_next[OFS_REM +: AMT_W]   = rem_reg;
                    m_tdata_next[OFS_FND +: FUNDS_W] = total_reg;
                    m_tuser_next  = status_reg;
                    state_next    = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            for (int i = 0; i < NUM_DENOMS; i++)
                stock_reg[i] <= STOCK_RESET;
            count_reg    <= '0;
            total_reg    <= FUNDS_RESET;
            amount_reg   <= '0;
            rem_reg      <= '0;
            idx_reg      <= '0;
            sum_reg      <= '0;
            status_reg   <= PAY_OK;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            stock_reg    <= stock_next;
            count_reg    <= count_next;
            total_reg    <= total_next;
            amount_reg   <= amount_next;
            rem_reg      <= rem_next;
            idx_reg      <= idx_next;
            sum_reg      <= sum_next;
            status_reg   <= status_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // funds only grow through a refill
    a_funds_no_growth: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_RMUL) |=> (total_reg <= $past(total_reg)))
        else $error("funds grew outside a refill");

    // the picker reports only while the sequencer waits for it
    a_pick_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        pick_res.done |-> (state_reg == ST_PWAIT))
        else $error("picker result outside its wait state");

    // a refused payout dispenses nothing
    a_refused_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == PAY_REFUSED)) |->
        ((m_tdata[OFS_CNT +: CNT_W * NUM_DENOMS] == '0) &&
         (m_tdata[OFS_REM +: AMT_W] == '0)))
        else $error("refused payout shows dispensed notes");

    // a refill result carries no payout amount
    a_refill_no_amount: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == PAY_REFILL)) |-> (m_tdata[0 +: AMT_W] == '0))
        else $error("refill result carries an amount");

endmodule

@@ dv/greedy_cash_dispenser_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_cash_dispenser_tb
// Self-checking bench for the cash dispenser. Requests go in on the slave
// stream and each accepted one is run through a local model of the note
// stocks to predict its result. Results are checked in order as they leave
// the master stream. Denominations and refill level are set over APB between
// phases while the block is idle. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module greedy_cash_dispenser_tb;
    import gcdisp_pkg::*;

    localparam int NDEN           = 5;
    localparam int AW             = $clog2(NDEN + 1) + 2;
    localparam int OUT_W          = 120;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 70;

    // register map, one word per register
    localparam int REG_DENOM0  = 0;
    localparam int REG_REFILL  = NDEN;
    localparam int REG_SPARE_A = NDEN + 1;
    localparam int REG_SPARE_B = NDEN + 2;

    localparam logic [DEN_W-1:0] DENOM_AT_RESET [NDEN] = '{16'd1, 16'd5, 16'd10, 16'd20,
                                                           16'd100};
    localparam logic [31:0] FUNDS_MASK = 32'h07FF_FFFF;
    localparam logic [31:0] MAX_AMOUNT = 32'd16711425;

    typedef struct packed {
        status_t                      status;
        logic [AMT_W-1:0]             amount;
        logic [NDEN-1:0][CNT_W-1:0]   notes;
        logic [AMT_W-1:0]             unpaid;
        logic [FUNDS_W-1:0]           funds;
    } payout_t;

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [23:0]        s_tdata;
    logic               s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [OUT_W-1:0]   m_tdata;
    logic [1:0]         m_tuser;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [AW-1:0]      paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    greedy_cash_dispenser #(.NUM_DENOMS(NDEN)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // odds[7:0], bet[23:8]
        .s_tuser  (s_tuser),   // req_type
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // amount, count_0..count_4, undispensed, funds_left
        .m_tuser  (m_tuser),   // status
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // local copy of the dispenser state and settings
    logic [DEN_W-1:0]   denom_cfg [NDEN];
    logic [CNT_W-1:0]   refill_cfg;
    logic [CNT_W-1:0]   note_stock [NDEN];
    logic [31:0]        vault_total;

    payout_t            pending_payouts [$];
    int                 error_count;
    int                 idle_cycles;
    bit                 quiet;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input longint unsigned got,
                                   input longint unsigned want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    function automatic logic [31:0] vault_value();
        logic [31:0] sum;
        sum = '0;
        for (int i = 0; i < NDEN; i++)
            sum = sum + note_stock[i] * denom_cfg[i];
        return sum & FUNDS_MASK;
    endfunction

    // greedy payout from the highest index down, each pick capped by its stock
    task automatic dispense_predict(input req_t req, input logic [ODDS_W-1:0] odds,
                                    input logic [BET_W-1:0] bet, output payout_t r);
        logic [31:0] left;
        logic [31:0] n;
        r = '0;
        if (req == REQ_REFILL)
        begin
            for (int i = 0; i < NDEN; i++)
                note_stock[i] = refill_cfg;
            vault_total = vault_value();
            r.status = PAY_REFILL;
        end
        else
        begin
            left = odds * bet;
            r.amount = left[AMT_W-1:0];
            if (left > vault_total)
                r.status = PAY_REFUSED;
            else
            begin
                r.status = PAY_OK;
                for (int i = NDEN - 1; i >= 0; i--)
                begin
                    n = (denom_cfg[i] == '0) ? 32'd0 : left / denom_cfg[i];
                    if (n > note_stock[i])
                        n = note_stock[i];
                    note_stock[i] = note_stock[i] - n[CNT_W-1:0];
                    left = left - n * denom_cfg[i];
                    vault_total = (vault_total - n * denom_cfg[i]) & FUNDS_MASK;
                    r.notes[i] = n[CNT_W-1:0];
                end
                r.unpaid = left[AMT_W-1:0];
            end
        end
        r.funds = vault_total[FUNDS_W-1:0];
    endtask

    // one request transaction; prediction is made at the accepting edge
    task automatic send_request(input req_t req, input logic [ODDS_W-1:0] odds,
                                input logic [BET_W-1:0] bet);
        payout_t r;
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 19);
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= {bet, odds};
        do
            @(posedge clk);
        while (!s_tready);
        dispense_predict(req, odds, bet, r);
        pending_payouts.push_back(r);
    endtask

    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_payouts.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic apb_write(input int idx, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= AW'(idx * 4);
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx >= REG_DENOM0 && idx < REG_REFILL)
            denom_cfg[idx] = value[DEN_W-1:0];
        else if (idx == REG_REFILL)
            refill_cfg = value[CNT_W-1:0];
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apb_read(input int idx, output logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= AW'(idx * 4);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        value = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_bank(input logic [DEN_W-1:0] d0, input logic [DEN_W-1:0] d1,
                            input logic [DEN_W-1:0] d2, input logic [DEN_W-1:0] d3,
                            input logic [DEN_W-1:0] d4, input logic [CNT_W-1:0] level);
        apb_write(REG_DENOM0 + 0, {16'h0000, d0});
        apb_write(REG_DENOM0 + 1, {16'h0000, d1});
        apb_write(REG_DENOM0 + 2, {16'h0000, d2});
        apb_write(REG_DENOM0 + 3, {16'h0000, d3});
        apb_write(REG_DENOM0 + 4, {16'h0000, d4});
        apb_write(REG_REFILL, {24'h000000, level});
    endtask

    // strictly ascending set whose values stay below top
    task automatic set_ascending_bank(input int top, input logic [CNT_W-1:0] level);
        int d [NDEN];
        d[0] = $urandom_range(1, top / 8);
        for (int i = 1; i < NDEN; i++)
            d[i] = d[i-1] + $urandom_range(1, top / 5);
        set_bank(DEN_W'(d[0]), DEN_W'(d[1]), DEN_W'(d[2]), DEN_W'(d[3]), DEN_W'(d[4]),
                 level);
    endtask

    // mostly payouts the vault can cover, some refills and some free-running noise
    task automatic send_random(input int count);
        int pick;
        logic [31:0] lim;
        logic [31:0] target;
        logic [ODDS_W-1:0] odds;
        logic [BET_W-1:0] bet;
        for (int k = 0; k < count; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 8)
                send_request(REQ_REFILL, ODDS_W'($urandom_range(0, 255)),
                             BET_W'($urandom_range(0, 65535)));
            else if (pick < 18)
                send_request(REQ_PAYOUT, ODDS_W'($urandom_range(0, 255)),
                             BET_W'($urandom_range(0, 65535)));
            else
            begin
                lim = (vault_total > MAX_AMOUNT) ? MAX_AMOUNT : vault_total;
                target = $urandom_range(0, lim);
                odds = (pick < 22) ? 8'd1 : 8'($urandom_range(1, 255));
                bet = (target / odds > 65535) ? 16'hFFFF : 16'(target / odds);
                send_request(REQ_PAYOUT, odds, bet);
            end
        end
    endtask

    task automatic test_reset_bank();
        send_request(REQ_PAYOUT, 8'd0, 16'd0);
        send_request(REQ_PAYOUT, 8'd255, 16'hFFFF);
        send_request(REQ_PAYOUT, 8'd10, 16'd100);
        send_request(REQ_PAYOUT, 8'd1, 16'd7);
        send_request(REQ_PAYOUT, 8'd1, 16'd353);
        // vault empty now
        send_request(REQ_PAYOUT, 8'd1, 16'd1);
        send_request(REQ_REFILL, 8'd255, 16'hFFFF);
        send_request(REQ_PAYOUT, 8'd0, 16'hFFFF);
        drain();
    endtask

    task automatic test_registers();
        logic [31:0] wval [NDEN + 1];
        logic [31:0] rval;
        for (int i = 0; i <= REG_REFILL; i++)
        begin
            wval[i] = $urandom;
            apb_write(i, wval[i]);
        end
        // writes outside the map must not land anywhere
        apb_write(REG_SPARE_A, $urandom);
        apb_write(REG_SPARE_B, $urandom);
        for (int i = 0; i <= REG_REFILL; i++)
        begin
            apb_read(i, rval);
            if (i == REG_REFILL && rval !== {24'h0, wval[i][CNT_W-1:0]})
                report_mismatch("refill_level readback", rval, wval[i][CNT_W-1:0]);
            else if (i != REG_REFILL && rval !== {16'h0, wval[i][DEN_W-1:0]})
                report_mismatch("denom readback", rval, wval[i][DEN_W-1:0]);
        end
    endtask

    task automatic test_odd_bank();
        // zero note, repeated value and a falling tail
        set_bank(16'd0, 16'd4, 16'd9, 16'd9, 16'd2, 8'd3);
        send_request(REQ_REFILL, 8'd0, 16'd0);
        send_request(REQ_PAYOUT, 8'd4, 16'd5);
        send_request(REQ_PAYOUT, 8'd1, 16'd1);
        send_request(REQ_PAYOUT, 8'd3, 16'd3);
        drain();
    endtask

    task automatic test_extremes();
        set_bank(16'd65531, 16'd65532, 16'd65533, 16'd65534, 16'd65535, 8'd255);
        send_request(REQ_REFILL, 8'd170, 16'h5555);
        send_request(REQ_PAYOUT, 8'd255, 16'hFFFF);
        send_request(REQ_PAYOUT, 8'd1, 16'd65534);
        drain();
        apb_write(REG_REFILL, 32'd0);
        send_request(REQ_REFILL, 8'd85, 16'hAAAA);
        send_request(REQ_PAYOUT, 8'd0, 16'd0);
        send_request(REQ_PAYOUT, 8'd1, 16'd1);
        drain();
    endtask

    task automatic test_random_reset_bank();
        set_bank(DENOM_AT_RESET[0], DENOM_AT_RESET[1], DENOM_AT_RESET[2],
                 DENOM_AT_RESET[3], DENOM_AT_RESET[4], 8'd10);
        send_random(350);
        drain();
    endtask

    task automatic test_random_small_notes();
        set_bank(16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 8'd255);
        send_random(250);
        drain();
    endtask

    task automatic test_random_large_vault();
        set_ascending_bank(65535, 8'd255);
        send_random(300);
        drain();
    endtask

    task automatic test_random_ascending();
        set_ascending_bank($urandom_range(40, 65535), 8'($urandom_range(0, 255)));
        send_random(300);
        drain();
    endtask

    task automatic test_random_any_bank();
        set_bank(DEN_W'($urandom_range(0, 65535)), DEN_W'($urandom_range(0, 200)),
                 DEN_W'($urandom_range(0, 50)), DEN_W'($urandom_range(0, 9)),
                 DEN_W'($urandom_range(0, 65535)), CNT_W'($urandom_range(1, 255)));
        send_random(300);
        drain();
    endtask

    task automatic test_random_back_to_back();
        quiet = 1'b1;
        set_ascending_bank(2000, 8'd200);
        send_random(380);
        drain();
    endtask

    // result checker
    always @(posedge clk)
    begin : check_payout
        payout_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_payouts.size() == 0)
                report_mismatch("result with nothing pending, amount", m_tdata[23:0], 0);
            else
            begin
                want = pending_payouts.pop_front();
                if (m_tuser !== want.status)
                    report_mismatch("status", m_tuser, want.status);
                if (m_tdata[23:0] !== want.amount)
                    report_mismatch("amount", m_tdata[23:0], want.amount);
                for (int i = 0; i < NDEN; i++)
                    if (m_tdata[24 + 8*i +: 8] !== want.notes[i])
                        report_mismatch($sformatf("count_%0d", i), m_tdata[24 + 8*i +: 8],
                                        want.notes[i]);
                if (m_tdata[64 +: 24] !== want.unpaid)
                    report_mismatch("undispensed", m_tdata[64 +: 24], want.unpaid);
                if (m_tdata[88 +: 27] !== want.funds)
                    report_mismatch("funds_left", m_tdata[88 +: 27], want.funds);
            end
        end
    end

    // receiver with random stall bursts
    initial
    begin : result_sink
        int stall;
        stall = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                stall--;
            end
            else if (!quiet && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 19) - 1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // watchdog: no transaction for too long ends the run
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        quiet       = 1'b0;
        error_count = 0;
        idle_cycles = 0;
        for (int i = 0; i < NDEN; i++)
        begin
            denom_cfg[i]  = DENOM_AT_RESET[i];
            note_stock[i] = STOCK_RESET;
        end
        refill_cfg  = REFILL_RESET;
        vault_total = vault_value();

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_bank();
        test_registers();
        test_odd_bank();
        test_extremes();
        test_random_reset_bank();
        test_random_small_notes();
        test_random_large_vault();
        test_random_ascending();
        test_random_any_bank();
        test_random_back_to_back();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_payouts.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
